@@ src/mmac_pkg.sv @@
// shared constants and types for the multiword multiply-accumulate unit
package mmac_pkg;

    localparam int WORD_BITS    = 64;
    localparam int LO_BITS      = WORD_BITS / 2;
    localparam int HI_BITS      = WORD_BITS - LO_BITS;
    localparam int PART_BITS    = 2 * HI_BITS;
    localparam int PROD_BITS    = 2 * WORD_BITS;
    localparam int SUM_BITS     = 2 * WORD_BITS + 2;
    localparam int CARRY_BITS   = WORD_BITS + 2;
    localparam int S_DATA_BITS  = ((2 * WORD_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS  = ((WORD_BITS + 7) / 8) * 8;
    localparam int S_USER_BITS  = 2;
    localparam int M_USER_BITS  = 1;
    localparam int CFG_IDX_BITS = 1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_MULT_LOW  = 1'b0,
        CFG_MULT_HIGH = 1'b1
    } cfg_idx_t;

    // four half-word partial products of one full-word product
    typedef struct packed {
        logic [PART_BITS-1:0] p11;
        logic [PART_BITS-1:0] p10;
        logic [PART_BITS-1:0] p01;
        logic [PART_BITS-1:0] p00;
    } part_t;

endpackage

@@ src/mmac_mul.sv @@
// registered half-word partial products of one word-by-word multiply
module mmac_mul (
    input  logic                           aclk,
    input  logic                           en,
    input  logic [mmac_pkg::WORD_BITS-1:0] x,
    input  logic [mmac_pkg::WORD_BITS-1:0] y,
    output mmac_pkg::part_t                part
);

    localparam int W  = mmac_pkg::WORD_BITS;
    localparam int LO = mmac_pkg::LO_BITS;
    localparam int PB = mmac_pkg::PART_BITS;

    mmac_pkg::part_t part_reg;
    mmac_pkg::part_t part_next;

    logic [LO-1:0] x0;
    logic [LO-1:0] y0;
    logic [W-LO-1:0] x1;
    logic [W-LO-1:0] y1;

    always_comb begin
        x0 = x[LO-1:0];
        x1 = x[W-1:LO];
        y0 = y[LO-1:0];
        y1 = y[W-1:LO];
        part_next.p00 = PB'(x0) * PB'(y0);
        part_next.p01 = PB'(x0) * PB'(y1);
        part_next.p10 = PB'(x1) * PB'(y0);
        part_next.p11 = PB'(x1) * PB'(y1);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            part_reg <= part_next;
        end
    end

    assign part = part_reg;

endmodule

@@ src/multiword_multiply_accumulate_unit.sv @@
// top level: streaming multiword multiply-accumulate by a two-word multiplier
//
//  channel   dir  tdata (low bit up)           tuser (low bit up)
//  s_        in   a_word, acc_word             first, a_valid
//  m_        out  acc_word_out                 carry_pending
//  cfg_      in   index 0 mult_low, 1 mult_high (write only)
//
// one item per cycle sustained while m_tready is high
// stages: input reg, 32x32 partial products, product combine, add of both products
// and the accumulator word, then the carry add into the output register
// the carry add in the last stage is the only loop and sets the one-cycle rate
// aresetn clears valids, carry, previous a word and both multiplier words
// each stage holds while the one after it is full and stalled; bubbles are absorbed
module multiword_multiply_accumulate_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mmac_pkg::S_DATA_BITS-1:0]  s_tdata,  // a_word, acc_word
    input  logic [mmac_pkg::S_USER_BITS-1:0]  s_tuser,  // first, a_valid
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mmac_pkg::M_DATA_BITS-1:0]  m_tdata,  // acc_word_out
    output logic [mmac_pkg::M_USER_BITS-1:0]  m_tuser,  // carry_pending
    input  logic                              cfg_we,
    input  logic [mmac_pkg::CFG_IDX_BITS-1:0] cfg_addr,
    input  logic [mmac_pkg::WORD_BITS-1:0]    cfg_wdata
);

    localparam int W   = mmac_pkg::WORD_BITS;
    localparam int LO  = mmac_pkg::LO_BITS;
    localparam int PRB = mmac_pkg::PROD_BITS;
    localparam int SB  = mmac_pkg::SUM_BITS;
    localparam int CB  = mmac_pkg::CARRY_BITS;
    localparam int PB  = mmac_pkg::PART_BITS;

    // configuration
    logic [W-1:0] mult_low_reg;
    logic [W-1:0] mult_high_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mult_low_reg  <= '0;
            mult_high_reg <= '0;
        end else if (cfg_we) begin
            case (mmac_pkg::cfg_idx_t'(cfg_addr))
                mmac_pkg::CFG_MULT_LOW:  mult_low_reg  <= cfg_wdata;
                mmac_pkg::CFG_MULT_HIGH: mult_high_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // per-stage ready
    logic va_reg, vb_reg, vc_reg, vd_reg, ve_reg;
    logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;

    assign rdy_e    = !ve_reg || m_tready;
    assign rdy_d    = !vd_reg || rdy_e;
    assign rdy_c    = !vc_reg || rdy_d;
    assign rdy_b    = !vb_reg || rdy_c;
    assign rdy_a    = !va_reg || rdy_b;
    assign s_tready = rdy_a;

    // stage a: input register and previous a word
    logic         in_first, in_a_valid;
    logic [W-1:0] in_a_word, in_acc_word, in_a_cur;
    logic [W-1:0] last_a_reg;
    logic         a_first_reg;
    logic [W-1:0] a_cur_reg, a_prev_reg, a_acc_reg;

    assign in_first    = s_tuser[0];
    assign in_a_valid  = s_tuser[1];
    assign in_a_word   = s_tdata[W-1:0];
    assign in_acc_word = s_tdata[2*W-1:W];
    assign in_a_cur    = in_a_valid ? in_a_word : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg     <= 1'b0;
            last_a_reg <= '0;
        end else if (rdy_a) begin
            va_reg <= s_tvalid;
            if (s_tvalid) begin
                last_a_reg <= in_a_cur;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_a) begin
            a_first_reg <= in_first;
            a_cur_reg   <= in_a_cur;
            a_prev_reg  <= in_first ? '0 : last_a_reg;
            a_acc_reg   <= in_acc_word;
        end
    end

    // stage b: partial products
    mmac_pkg::part_t part0, part1;
    logic            b_first_reg;
    logic [W-1:0]    b_acc_reg;

    mmac_mul u_mul_low (
        .aclk (aclk),
        .en   (rdy_b),
        .x    (a_cur_reg),
        .y    (mult_low_reg),
        .part (part0)
    );

    mmac_mul u_mul_high (
        .aclk (aclk),
        .en   (rdy_b),
        .x    (a_prev_reg),
        .y    (mult_high_reg),
        .part (part1)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
        end else if (rdy_b) begin
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_b) begin
            b_first_reg <= a_first_reg;
            b_acc_reg   <= a_acc_reg;
        end
    end

    // stage c: combine partials into full products
    logic [PB:0]    mid0, mid1;
    logic [PRB-1:0] prod0_next, prod1_next;
    logic [PRB-1:0] c_prod0_reg, c_prod1_reg;
    logic           c_first_reg;
    logic [W-1:0]   c_acc_reg;

    always_comb begin
        mid0 = (PB+1)'(part0.p01) + (PB+1)'(part0.p10);
        mid1 = (PB+1)'(part1.p01) + (PB+1)'(part1.p10);
        prod0_next = PRB'(part0.p00) + (PRB'(mid0) << LO) + (PRB'(part0.p11) << (2 * LO));
        prod1_next = PRB'(part1.p00) + (PRB'(mid1) << LO) + (PRB'(part1.p11) << (2 * LO));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg <= 1'b0;
        end else if (rdy_c) begin
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_c) begin
            c_first_reg <= b_first_reg;
            c_acc_reg   <= b_acc_reg;
            c_prod0_reg <= prod0_next;
            c_prod1_reg <= prod1_next;
        end
    end

    // stage d: both products plus the accumulator word
    logic [SB-1:0] sum_next, d_sum_reg;
    logic          d_first_reg;

    assign sum_next = SB'(c_prod0_reg) + SB'(c_prod1_reg) + SB'(c_acc_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vd_reg <= 1'b0;
        end else if (rdy_d) begin
            vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_d) begin
            d_first_reg <= c_first_reg;
            d_sum_reg   <= sum_next;
        end
    end

    // stage e: running carry add, output register
    logic [CB-1:0] carry_reg, carry_in, carry_next;
    logic [SB-1:0] total;
    logic [W-1:0]  e_acc_reg;
    logic          e_pend_reg;

    always_comb begin
        carry_in   = d_first_reg ? '0 : carry_reg;
        total      = d_sum_reg + SB'(carry_in);
        carry_next = total[SB-1:W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ve_reg    <= 1'b0;
            carry_reg <= '0;
        end else if (rdy_e) begin
            ve_reg <= vd_reg;
            if (vd_reg) begin
                carry_reg <= carry_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_e && vd_reg) begin
            e_acc_reg  <= total[W-1:0];
            e_pend_reg <= |carry_next;
        end
    end

    assign m_tvalid = ve_reg;
    assign m_tdata  = mmac_pkg::M_DATA_BITS'(e_acc_reg);
    assign m_tuser  = e_pend_reg;

    // checks
    ap_pend_matches_carry: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[0] == (carry_reg != '0)))
        else $error("carry_pending disagrees with held carry");

    ap_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    ap_carry_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !(vd_reg && rdy_e) |=> $stable(carry_reg))
        else $error("carry changed without an item entering the output stage");

endmodule

@@ test/testbench.sv @@
// testbench for the multiword multiply-accumulate unit: directed and random streams
`timescale 1ns / 1ps

module testbench;

    localparam int W           = mmac_pkg::WORD_BITS;
    localparam int SB          = mmac_pkg::SUM_BITS;
    localparam int CB          = mmac_pkg::CARRY_BITS;
    localparam int LATENCY     = 5;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RAND_ITEMS  = 1800;
    localparam int PHASES      = 8;

    typedef struct {
        logic [W-1:0] word;
        logic         pending;
    } mac_result_t;

    typedef enum int {SEQ_FULL, SEQ_CUT, SEQ_NO_FIRST, SEQ_NOISE} seq_kind_t;

    // running t += a * (mult_high:mult_low), one word position per item
    class mac_scoreboard;
        logic [W-1:0]  mult_lo;
        logic [W-1:0]  mult_hi;
        logic [W-1:0]  prev_a;
        logic [CB-1:0] carry;
        mac_result_t   expected[$];
        int            errors;

        function new();
            mult_lo = '0;
            mult_hi = '0;
            prev_a  = '0;
            carry   = '0;
            errors  = 0;
        endfunction

        function void set_mult(mmac_pkg::cfg_idx_t idx, logic [W-1:0] value);
            if (idx == mmac_pkg::CFG_MULT_LOW) mult_lo = value;
            else mult_hi = value;
        endfunction

        function bit carry_live();
            return carry != '0;
        endfunction

        function int pending();
            return expected.size();
        endfunction

        function void note_item(logic first, logic a_valid, logic [W-1:0] a_word,
                                logic [W-1:0] acc_word);
            logic [W-1:0]  a_cur;
            logic [SB-1:0] sum;
            mac_result_t   r;
            if (first) begin
                carry  = '0;
                prev_a = '0;
            end
            a_cur = a_valid ? a_word : '0;
            sum = {{(SB-W){1'b0}}, a_cur} * {{(SB-W){1'b0}}, mult_lo}
                + {{(SB-W){1'b0}}, prev_a} * {{(SB-W){1'b0}}, mult_hi}
                + {{(SB-W){1'b0}}, acc_word}
                + {{(SB-CB){1'b0}}, carry};
            r.word    = sum[W-1:0];
            carry     = sum[SB-1:W];
            r.pending = carry != '0;
            prev_a    = a_cur;
            expected.push_back(r);
        endfunction

        function void check_result(logic [W-1:0] word, logic pending_flag);
            mac_result_t e;
            if (expected.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: result with nothing expected: word %h pending %b",
                             $realtime, word, pending_flag);
                return;
            end
            e = expected.pop_front();
            if (word !== e.word) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: acc_word_out mismatch: expected %h got %h",
                             $realtime, e.word, word);
            end
            if (pending_flag !== e.pending) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: carry_pending mismatch: expected %b got %b",
                             $realtime, e.pending, pending_flag);
            end
        endfunction
    endclass

    logic                              aclk = 1'b0;
    logic                              aresetn;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [mmac_pkg::S_DATA_BITS-1:0]  s_tdata;
    logic [mmac_pkg::S_USER_BITS-1:0]  s_tuser;
    logic                              m_tvalid;
    logic                              m_tready;
    logic [mmac_pkg::M_DATA_BITS-1:0]  m_tdata;
    logic [mmac_pkg::M_USER_BITS-1:0]  m_tuser;
    logic                              cfg_we;
    logic [mmac_pkg::CFG_IDX_BITS-1:0] cfg_addr;
    logic [W-1:0]                      cfg_wdata;

    mac_scoreboard sb = new();

    bit no_gaps = 1'b0;
    int cycles = 0;
    int items_sent = 0;
    int results_seen = 0;
    int carry_seen = 0;
    int sequences = 0;
    int settings = 0;

    multiword_multiply_accumulate_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata[W-1:0], m_tuser[0]);
            results_seen++;
            if (m_tuser[0]) carry_seen++;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // biased toward all-ones, zero, single-bit and single-clear-bit words to stress the carry
    function automatic logic [W-1:0] rand_word();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: return '1;
            1: return '0;
            2: return W'(1) << $urandom_range(0, W - 1);
            3: return ~(W'(1) << $urandom_range(0, W - 1));
            default: return r[W-1:0];
        endcase
    endfunction

    initial begin
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            int stall;
            stall = idle_len();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    end

    task automatic push_word(input logic first, input logic a_valid,
                             input logic [W-1:0] a_word, input logic [W-1:0] acc_word);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= mmac_pkg::S_DATA_BITS'({acc_word, a_word});
        s_tuser  <= {a_valid, first};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_item(first, a_valid, a_word, acc_word);
        items_sent++;
        gap = idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // stop sending and let the pipeline empty
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (LATENCY + 3) @(posedge aclk);
    endtask

    task automatic cfg_write(input mmac_pkg::cfg_idx_t idx, input logic [W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        sb.set_mult(idx, value);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_multiplier(input logic [W-1:0] lo, input logic [W-1:0] hi);
        cfg_write(mmac_pkg::CFG_MULT_LOW, lo);
        cfg_write(mmac_pkg::CFG_MULT_HIGH, hi);
        settings++;
    endtask

    // most streams: a run of a words, then a-masked words until the carry is out
    task automatic run_sequence(input seq_kind_t kind);
        int n;
        int tail;
        int tail_min;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
        if (kind == SEQ_NOISE) begin
            repeat (n) push_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                 rand_word(), rand_word());
        end else begin
            for (int i = 0; i < n; i++)
                push_word(i == 0 && kind != SEQ_NO_FIRST, 1'b1, rand_word(), rand_word());
            tail = 0;
            tail_min = (kind == SEQ_CUT) ? $urandom_range(0, 1) : 2;
            while (tail < tail_min || (kind != SEQ_CUT && sb.carry_live() && tail < 24)) begin
                push_word(1'b0, 1'b0, rand_word(), rand_word());
                tail++;
            end
        end
        sequences++;
    endtask

    initial begin
        int phase_items;
        int r;
        logic [W-1:0] lo;
        logic [W-1:0] hi;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_we    <= 1'b0;
        cfg_addr  <= mmac_pkg::CFG_MULT_LOW;
        cfg_wdata <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // multiplier is zero out of reset: t passes through
        push_word(1'b1, 1'b1, '1, '1);
        drain();

        // largest carry: all-ones operands and multiplier
        set_multiplier('1, '1);
        push_word(1'b1, 1'b1, '1, '1);
        push_word(1'b0, 1'b1, '1, '1);
        push_word(1'b0, 1'b0, '1, '1);     // masked a word must be ignored
        push_word(1'b0, 1'b0, '0, '1);
        push_word(1'b0, 1'b0, '0, '0);
        push_word(1'b1, 1'b1, '0, '0);
        push_word(1'b1, 1'b0, '1, '0);
        push_word(1'b0, 1'b1, {1'b1, {(W-1){1'b0}}}, '1);   // continues without first
        push_word(1'b1, 1'b1, W'(1), '0);                   // first drops a live carry
        push_word(1'b0, 1'b0, '1, '0);
        push_word(1'b0, 1'b0, '0, '0);
        drain();

        // unit low word, then a one-word shift through the high word
        set_multiplier(W'(1), '0);
        push_word(1'b1, 1'b1, {(W/2){2'b01}}, {(W/2){2'b10}});
        push_word(1'b0, 1'b0, '0, '0);
        drain();
        set_multiplier('0, W'(1));
        push_word(1'b1, 1'b1, '1, '0);
        push_word(1'b0, 1'b0, '0, '0);
        push_word(1'b0, 1'b0, '0, '0);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin lo = rand_word(); hi = rand_word(); end
                1: begin lo = '1; hi = '1; end
                2: begin lo = '0; hi = rand_word(); end
                3: begin lo = rand_word(); hi = '0; end
                4: begin lo = {1'b1, {(W-1){1'b0}}}; hi = {1'b1, {(W-1){1'b0}}}; end
                5: begin lo = '0; hi = '0; end
                default: begin lo = {$urandom, $urandom}; hi = {$urandom, $urandom}; end
            endcase
            set_multiplier(lo, hi);
            no_gaps = (p == 2 || p == 5);
            phase_items = items_sent + RAND_ITEMS / PHASES;
            while (items_sent < phase_items) begin
                r = $urandom_range(0, 99);
                if (r < 75) run_sequence(SEQ_FULL);
                else if (r < 85) run_sequence(SEQ_CUT);
                else if (r < 90) run_sequence(SEQ_NO_FIRST);
                else run_sequence(SEQ_NOISE);
                // in phase 3, every 40th sequence waits until every result is back
                if (p == 3 && sequences % 40 == 0) drain();
            end
            drain();
        end
        no_gaps = 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);

        $display("covered %0d random word streams over %0d multiplier settings plus directed",
                 sequences, settings);
        $display("%0d items sent, %0d results checked, %0d with carry pending, %0d cycles",
                 items_sent, results_seen, carry_seen, cycles);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
